FILE: rtl/mbfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_pkg
// Shared types, register indexes and the Modbus CRC-16 byte update.
// ----------------------------------------------------------------------------
package mbfc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [15:0] TIMEOUT_RESET  = 16'd14560;
    localparam logic [8:0]  EXP_LEN_RESET  = 9'd100;
    localparam logic [7:0]  EXP_ADDR_RESET = 8'h01;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_EXP_LEN  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_EXP_ADDR = 2'd2;

    localparam logic EV_BYTE = 1'b0;
    localparam logic EV_TICK = 1'b1;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [8:0]  expected_length;
        logic [7:0]  expected_address;
    } cfg_t;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [8:0]  frame_length;
        logic        length_ok;
        logic        address_ok;
        logic        crc_ok;
        logic        frame_valid;
        logic [15:0] received_crc;
        logic [15:0] computed_crc;
        logic        overflow;
    } result_t;

    // bitwise reflected update, eight shift steps
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

FILE: rtl/mbfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc channel interfaces
// Event input, verdict output and configuration write channels.
// ----------------------------------------------------------------------------
interface mbfc_event_if;
    logic       valid;
    logic       ready;
    logic       event_kind;
    logic [7:0] data_byte;

    modport source (output valid, event_kind, data_byte, input ready);
    modport sink   (input valid, event_kind, data_byte, output ready);
endinterface

interface mbfc_verdict_if;
    logic        valid;
    logic        ready;
    logic [8:0]  frame_length;
    logic        length_ok;
    logic        address_ok;
    logic        crc_ok;
    logic        frame_valid;
    logic [15:0] received_crc;
    logic [15:0] computed_crc;
    logic        overflow;

    modport source (output valid, frame_length, length_ok, address_ok, crc_ok, frame_valid,
                    received_crc, computed_crc, overflow, input ready);
    modport sink   (input valid, frame_length, length_ok, address_ok, crc_ok, frame_valid,
                    received_crc, computed_crc, overflow, output ready);
endinterface

interface mbfc_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mbfc_pkg::CFG_INDEX_W-1:0]   index;
    logic [mbfc_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/modbus_rtu_frame_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modbus_rtu_frame_checker_top
// Modbus RTU frame checker: collects bytes, times inter-frame silence and
// reports length, address and CRC-16 verdict for every ended frame.
// ----------------------------------------------------------------------------
//  channel   | role   | payload
//  rx_event  | sink   | event_kind (0 byte, 1 tick), data_byte
//  verdict   | source | frame_length, checks, received/computed crc, overflow
//  cfg       | sink   | index (0 timeout, 1 length, 2 address), data
//
//  one event per unstalled cycle; each event passes the input register and
//  updates the frame state once taken; a verdict appears in the cycle after
//  the ending tick is taken. crc is one byte per unstalled cycle through an
//  eight-step bit update. reset is asynchronous and active low, no clearing
//  pass. a stalled verdict holds the result register; the input register
//  still drains while it is empty or the verdict is taken in the same cycle.
// ----------------------------------------------------------------------------
module modbus_rtu_frame_checker_top
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    mbfc_event_if.sink      rx_event,
    mbfc_verdict_if.source  verdict,
    mbfc_cfg_if.sink        cfg
);

    mbfc_pkg::cfg_t  regs;
    mbfc_pkg::item_t item;
    logic            item_valid;
    logic            take;

    mbfc_cfg_regs u_cfg_regs
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    mbfc_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_event   (rx_event),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    mbfc_frame_core
    #(
        .MAX_FRAME (MAX_FRAME)
    )
    u_frame_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .regs       (regs),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .verdict    (verdict)
    );

endmodule

FILE: rtl/mbfc_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_cfg_regs
// Configuration register file: timeout, expected length, expected address.
// ----------------------------------------------------------------------------
module mbfc_cfg_regs
(
    input  logic            clk,
    input  logic            rst_n,
    mbfc_cfg_if.sink        cfg,
    output mbfc_pkg::cfg_t  regs
);

    mbfc_pkg::cfg_t regs_reg;
    mbfc_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mbfc_pkg::REG_TIMEOUT:  regs_next.timeout_ticks    = cfg.data;
                mbfc_pkg::REG_EXP_LEN:  regs_next.expected_length  = cfg.data[8:0];
                mbfc_pkg::REG_EXP_ADDR: regs_next.expected_address = cfg.data[7:0];
                default:                regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.timeout_ticks    <= mbfc_pkg::TIMEOUT_RESET;
            regs_reg.expected_length  <= mbfc_pkg::EXP_LEN_RESET;
            regs_reg.expected_address <= mbfc_pkg::EXP_ADDR_RESET;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

FILE: rtl/mbfc_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_in_stage
// Input register for receive events, released when the frame core takes it.
// ----------------------------------------------------------------------------
module mbfc_in_stage
(
    input  logic            clk,
    input  logic            rst_n,
    mbfc_event_if.sink      rx_event,
    input  logic            take,
    output logic            item_valid,
    output mbfc_pkg::item_t item
);

    logic            valid_reg;
    logic            valid_next;
    mbfc_pkg::item_t item_reg;
    logic            load;

    assign rx_event.ready = !valid_reg || take;
    assign load           = rx_event.valid && rx_event.ready;
    assign item_valid     = valid_reg;
    assign item           = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (take)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.event_kind <= rx_event.event_kind;
            item_reg.data_byte  <= rx_event.data_byte;
        end
    end

endmodule

FILE: rtl/mbfc_frame_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbfc_frame_core
// Frame state, delayed CRC, silence timer and the registered verdict.
// ----------------------------------------------------------------------------
module mbfc_frame_core
#(
    parameter int MAX_FRAME = 256
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  mbfc_pkg::cfg_t  regs,
    input  logic            item_valid,
    input  mbfc_pkg::item_t item,
    output logic            take,
    mbfc_verdict_if.source  verdict
);

    localparam int CW = $clog2(MAX_FRAME + 1);
    localparam int LW = (CW > 9) ? CW : 9;

    logic [CW-1:0]      byte_count_reg,    byte_count_next;
    logic [15:0]        silence_count_reg, silence_count_next;
    logic               timer_running_reg, timer_running_next;
    logic [15:0]        crc_reg,           crc_next;
    logic [15:0]        tail_bytes_reg,    tail_bytes_next;
    logic [7:0]         first_byte_reg,    first_byte_next;
    logic               overflow_flag_reg, overflow_flag_next;

    logic               out_valid_reg,     out_valid_next;
    mbfc_pkg::result_t  result_reg;
    mbfc_pkg::result_t  result_calc;

    logic               advance;
    logic               fire;
    logic               emit;
    logic [15:0]        silence_inc;
    logic [15:0]        limit;
    logic               has_two;
    logic [15:0]        rx_crc;

    assign advance = !out_valid_reg || verdict.ready;
    assign take    = item_valid && advance;
    assign fire    = take;

    assign silence_inc = (silence_count_reg == 16'hFFFF) ? silence_count_reg
                                                         : 16'(silence_count_reg + 16'd1);
    assign limit   = (regs.timeout_ticks == 16'd0) ? 16'd1 : regs.timeout_ticks;
    assign has_two = byte_count_reg >= CW'(2);
    assign rx_crc  = has_two ? tail_bytes_reg : 16'h0000;

    always_comb
    begin
        result_calc.frame_length = 9'(byte_count_reg);
        result_calc.length_ok    = LW'(byte_count_reg) == LW'(regs.expected_length);
        result_calc.address_ok   = first_byte_reg == regs.expected_address;
        result_calc.crc_ok       = has_two && (rx_crc == crc_reg);
        result_calc.frame_valid  = result_calc.length_ok && result_calc.address_ok
                                   && result_calc.crc_ok;
        result_calc.received_crc = rx_crc;
        result_calc.computed_crc = crc_reg;
        result_calc.overflow     = overflow_flag_reg;
    end

    always_comb
    begin
        byte_count_next    = byte_count_reg;
        silence_count_next = silence_count_reg;
        timer_running_next = timer_running_reg;
        crc_next           = crc_reg;
        tail_bytes_next    = tail_bytes_reg;
        first_byte_next    = first_byte_reg;
        overflow_flag_next = overflow_flag_reg;
        emit               = 1'b0;
        if (fire)
        begin
            if (item.event_kind == mbfc_pkg::EV_BYTE)
            begin
                silence_count_next = 16'd0;
                timer_running_next = 1'b1;
                if (byte_count_reg < CW'(MAX_FRAME))
                begin
                    if (byte_count_reg == '0)
                        first_byte_next = item.data_byte;
                    // the two newest bytes stay out of the crc until a later byte pushes them
                    if (has_two)
                        crc_next = mbfc_pkg::crc_feed(crc_reg, tail_bytes_reg[7:0]);
                    tail_bytes_next = {item.data_byte, tail_bytes_reg[15:8]};
                    byte_count_next = CW'(byte_count_reg + CW'(1));
                end
                else
                begin
                    overflow_flag_next = 1'b1;
                end
            end
            else if (timer_running_reg)
            begin
                if (silence_inc < limit)
                begin
                    silence_count_next = silence_inc;
                end
                else
                begin
                    emit               = byte_count_reg != '0;
                    byte_count_next    = '0;
                    silence_count_next = 16'd0;
                    timer_running_next = 1'b0;
                    crc_next           = mbfc_pkg::CRC_INIT;
                    tail_bytes_next    = 16'h0000;
                    first_byte_next    = 8'h00;
                    overflow_flag_next = 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = emit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg    <= '0;
            silence_count_reg <= 16'd0;
            timer_running_reg <= 1'b0;
            crc_reg           <= mbfc_pkg::CRC_INIT;
            tail_bytes_reg    <= 16'h0000;
            first_byte_reg    <= 8'h00;
            overflow_flag_reg <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            byte_count_reg    <= byte_count_next;
            silence_count_reg <= silence_count_next;
            timer_running_reg <= timer_running_next;
            crc_reg           <= crc_next;
            tail_bytes_reg    <= tail_bytes_next;
            first_byte_reg    <= first_byte_next;
            overflow_flag_reg <= overflow_flag_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            result_reg <= result_calc;
    end

    assign verdict.valid        = out_valid_reg;
    assign verdict.frame_length = result_reg.frame_length;
    assign verdict.length_ok    = result_reg.length_ok;
    assign verdict.address_ok   = result_reg.address_ok;
    assign verdict.crc_ok       = result_reg.crc_ok;
    assign verdict.frame_valid  = result_reg.frame_valid;
    assign verdict.received_crc = result_reg.received_crc;
    assign verdict.computed_crc = result_reg.computed_crc;
    assign verdict.overflow     = result_reg.overflow;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg <= CW'(MAX_FRAME))
        else $error("byte count beyond frame capacity");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !timer_running_reg |-> (byte_count_reg == '0 && !overflow_flag_reg))
        else $error("frame data held with timer stopped");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_flag_reg |-> byte_count_reg == CW'(MAX_FRAME))
        else $error("overflow flagged on a frame that is not full");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (byte_count_reg == '0 && crc_reg == mbfc_pkg::CRC_INIT && out_valid_reg))
        else $error("frame state not cleared after verdict");

    a_verdict_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> verdict.frame_length != 9'd0 || LW > 9)
        else $error("verdict for empty frame");
`endif

endmodule
